// ===== rtl/core/lepg_pkg.sv =====
// Shared types, constants and the sine table function of the envelope generator.
// No dependencies; imported by lepg_if, lepg_sine and the top level.
`default_nettype none

package lepg_pkg;

  localparam int SINE_DEPTH_DEF    = 256;
  localparam int PROGRESS_BITS_DEF = 17;

  localparam int FUNC_W     = 4;
  localparam int PERIOD_W   = 15;
  localparam int PHASE_W    = 16;
  localparam int LEVEL_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PERIOD_W;
  localparam int DIV_NUM_W  = PERIOD_W + FRAC_W;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);

  localparam logic [PERIOD_W-1:0] RST_FULL_PERIOD  = PERIOD_W'(1000);
  localparam logic [PERIOD_W-1:0] RST_SHORT_PERIOD = PERIOD_W'(800);
  localparam logic [PERIOD_W-1:0] RST_RAMP_LENGTH  = PERIOD_W'(700);

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_PERIOD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH  = CFG_IDX_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_ZERO     = 4'd0,
    FN_FULL     = 4'd1,
    FN_DECAY_F  = 4'd2,
    FN_DECAY_S  = 4'd3,
    FN_DECAY4_F = 4'd4,
    FN_DECAY4_S = 4'd5,
    FN_SINE     = 4'd6,
    FN_SQ2_F    = 4'd7,
    FN_SQ2_S    = 4'd8,
    FN_SQ1_F    = 4'd9,
    FN_SQ1_S    = 4'd10,
    FN_RAMP_ON  = 4'd11,
    FN_RAMP_OFF = 4'd12
  } func_t;

  // operands after the mod stage, before the long divider
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                neg;
    logic                lt_per;
    logic                lt_ramp;
    logic [PERIOD_W-1:0] q;
    logic [PERIOD_W-1:0] m;
    logic [PERIOD_W-1:0] pv;
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W-1:0] len;
    logic [PHASE_W-1:0]  phase;
  } prep_t;

  // what rides alongside the long divider
  typedef struct packed {
    logic               use_div;
    logic               is_sine;
    logic [LEVEL_W-1:0] fixed_lvl;
    logic [PHASE_W-1:0] phase;
  } div_side_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [63:0] TAYLOR_DIV [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // sin(x) for x in Q30, Taylor series to x^17, rounded to Q16
  function automatic logic [LEVEL_W-1:0] sine_q16_of_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        rnd;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    rnd = ($unsigned(sum) + 64'd8192) >> 14;
    if (rnd > 64'd65536) rnd = 64'd65536;
    return rnd[LEVEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lepg_if.sv =====
// Valid/ready channel interfaces for the envelope generator input and result.
// Depends on lepg_pkg.
`default_nettype none

interface lepg_in_if
  import lepg_pkg::*;
#(
  parameter int PROGRESS_BITS = PROGRESS_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [FUNC_W-1:0]               func;
  logic signed [PROGRESS_BITS-1:0] progress;
  logic [PHASE_W-1:0]              phase_turn;

  modport source (output valid, func, progress, phase_turn, input ready);
  modport sink   (input valid, func, progress, phase_turn, output ready);
endinterface

interface lepg_out_if
  import lepg_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lepg_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Depends on lepg_pkg only through its users; stand-alone logic.
`default_nettype none

module lepg_udiv #(
  parameter int  NUM_W = 17,
  parameter int  DEN_W = 15,
  parameter type side_t = logic
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire side_t            side_in,
  output logic                  out_valid,
  output logic      [NUM_W-1:0] quo,
  output logic      [DEN_W-1:0] rem,
  output side_t                 side_out
);

  logic             valid_r [0:NUM_W];
  logic [DEN_W-1:0] rem_r   [0:NUM_W];
  logic [NUM_W-1:0] num_r   [0:NUM_W];
  logic [DEN_W-1:0] den_r   [0:NUM_W];
  side_t            side_r  [0:NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      rem_r[0]   <= '0;
      num_r[0]   <= num;
      den_r[0]   <= den;
      side_r[0]  <= side_in;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_step
    logic [DEN_W:0]   tr;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] num_nxt;

    // shift in next numerator bit, subtract if it fits
    assign tr      = {rem_r[i], num_r[i][NUM_W-1]};
    assign ge      = tr >= {1'b0, den_r[i]};
    assign diff    = tr - {1'b0, den_r[i]};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : tr[DEN_W-1:0];
    assign num_nxt = {num_r[i][NUM_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (en) begin
        valid_r[i+1] <= valid_r[i];
        rem_r[i+1]   <= rem_nxt;
        num_r[i+1]   <= num_nxt;
        den_r[i+1]   <= den_r[i];
        side_r[i+1]  <= side_r[i];
      end
    end
  end

  assign out_valid = valid_r[NUM_W];
  assign quo       = num_r[NUM_W];
  assign rem       = rem_r[NUM_W];
  assign side_out  = side_r[NUM_W];

endmodule

`default_nettype wire

// ===== rtl/core/lepg_sine.sv =====
// Raised sine from a 16-bit angle: index, quadrant fold, quarter-wave table.
// Depends on lepg_pkg (table function, widths). Three register stages.
`default_nettype none

module lepg_sine
  import lepg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [PHASE_W-1:0] angle,
  output logic      [LEVEL_W-1:0] level
);

  localparam int STEPS  = 4 * SINE_TABLE_DEPTH;
  localparam int IDX_W  = $clog2(STEPS + 1);
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W = PHASE_W + IDX_W + 1;

  logic [LEVEL_W-1:0] rom_w [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XQ30 = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2))
                                   / 64'(SINE_TABLE_DEPTH);
    localparam logic [LEVEL_W-1:0] ENTRY = sine_q16_of_q30(XQ30);
    assign rom_w[k] = ENTRY;
  end

  // stage 1: table index, rounded, wrapped
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   idx_raw;
  logic [IDX_W-1:0]   idx_nxt;
  logic [IDX_W-1:0]   idx_r;

  assign prod    = PROD_W'(angle) * PROD_W'(STEPS) + PROD_W'(32768);
  assign idx_raw = IDX_W'(prod >> FRAC_W);
  assign idx_nxt = (idx_raw == IDX_W'(STEPS)) ? '0 : idx_raw;

  // stage 2: quadrant fold
  logic [1:0]        quad;
  logic [IDX_W-1:0]  rel;
  logic [ADDR_W-1:0] addr_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic              neg_nxt;
  logic              neg_r;

  always_comb begin
    priority if (idx_r >= IDX_W'(3 * SINE_TABLE_DEPTH)) begin
      quad = 2'd3;
      rel  = idx_r - IDX_W'(3 * SINE_TABLE_DEPTH);
    end else if (idx_r >= IDX_W'(2 * SINE_TABLE_DEPTH)) begin
      quad = 2'd2;
      rel  = idx_r - IDX_W'(2 * SINE_TABLE_DEPTH);
    end else if (idx_r >= IDX_W'(SINE_TABLE_DEPTH)) begin
      quad = 2'd1;
      rel  = idx_r - IDX_W'(SINE_TABLE_DEPTH);
    end else begin
      quad = 2'd0;
      rel  = idx_r;
    end
  end

  assign addr_nxt = quad[0] ? ADDR_W'(SINE_TABLE_DEPTH) - ADDR_W'(rel) : ADDR_W'(rel);
  assign neg_nxt  = quad[1];

  // stage 3: table read, offset and halve
  logic [LEVEL_W-1:0] entry;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] level_nxt;
  logic [LEVEL_W-1:0] level_r;

  assign entry     = rom_w[addr_r];
  assign sum       = neg_r ? (LEVEL_W'(65537) - {1'b0, entry})
                           : ((LEVEL_W+1)'(65537) + {1'b0, entry});
  assign level_nxt = sum[LEVEL_W:1];

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r   <= idx_nxt;
      addr_r  <= addr_nxt;
      neg_r   <= neg_nxt;
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

// ===== rtl/core/light_envelope_pattern_generator.sv =====
// Top level of the light envelope pattern generator: config registers,
// operand prep, two pipelined dividers and the sine stage. Depends on
// lepg_pkg, lepg_if, lepg_udiv and lepg_sine.
//
//  channel  | dir | transfer when              | payload
//  ---------+-----+----------------------------+------------------------------
//  in_ch    | in  | in_ch.valid & in_ch.ready  | func, progress, phase_turn
//  out_ch   | out | out_ch.valid & out_ch.ready| level (Q1.16)
//  cfg_*    | in  | cfg_we                     | cfg_index, cfg_wdata
//
// One item a cycle while the output is not held, through the bit-per-stage mod
// divider, the prep stage, the bit-per-stage level divider and the sine stages.
// Reset (synchronous, rst_n low) clears all valid bits and loads the register
// defaults; no table clearing, the sine table is constant.
// A stall at the output freezes every stage at once; in_ch.ready falls with it.
`default_nettype none

module light_envelope_pattern_generator
  import lepg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int PROGRESS_BITS    = PROGRESS_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lepg_in_if.sink                    in_ch,
  lepg_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CMP_W = (PROGRESS_BITS > PERIOD_W) ? PROGRESS_BITS : PERIOD_W;
  localparam int T_W   = PERIOD_W + 2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic                     neg;
    logic [PROGRESS_BITS-1:0] mag;
    logic [PHASE_W-1:0]       phase;
  } mod_side_t;

  // ---------------------------------------------------------------------------
  // config registers (to be written only while idle; the user must ensure this, the block does not enforce it)
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] full_period_r;
  logic [PERIOD_W-1:0] short_period_r;
  logic [PERIOD_W-1:0] ramp_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_period_r  <= RST_FULL_PERIOD;
      short_period_r <= RST_SHORT_PERIOD;
      ramp_length_r  <= RST_RAMP_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_PERIOD:  full_period_r  <= cfg_wdata;
        CFG_SHORT_PERIOD: short_period_r <= cfg_wdata;
        CFG_RAMP_LENGTH:  ramp_length_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // single pipeline enable: everything moves unless the output is held
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------------
  // entry: split progress into sign and magnitude, |p| mod full_period
  // ---------------------------------------------------------------------------
  logic [PROGRESS_BITS-1:0] prog_u;
  logic                     neg_in;
  mod_side_t                mod_side_in;

  assign prog_u = in_ch.progress;
  assign neg_in = prog_u[PROGRESS_BITS-1];

  always_comb begin
    mod_side_in.func  = in_ch.func;
    mod_side_in.neg   = neg_in;
    mod_side_in.mag   = neg_in ? (~prog_u + 1'b1) : prog_u;
    mod_side_in.phase = in_ch.phase_turn;
  end

  logic                mod_valid;
  logic [PERIOD_W-1:0] mod_rem;
  mod_side_t           mod_side;

  lepg_udiv #(
    .NUM_W  (PROGRESS_BITS),
    .DEN_W  (PERIOD_W),
    .side_t (mod_side_t)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .num       (mod_side_in.mag),
    .den       (full_period_r),
    .side_in   (mod_side_in),
    .out_valid (mod_valid),
    .quo       (),
    .rem       (mod_rem),
    .side_out  (mod_side)
  );

  // ---------------------------------------------------------------------------
  // prep stage: period select, range checks, repeated-pattern mod, sine offset
  // ---------------------------------------------------------------------------
  logic                sel_short;
  logic [PERIOD_W-1:0] per;
  logic [T_W-1:0]      t;
  logic [T_W-1:0]      per1;
  logic [T_W-1:0]      per2;
  logic [T_W-1:0]      per3;
  logic [T_W-1:0]      tq;
  prep_t               p1_nxt;
  prep_t               p1_r;
  logic                p1_valid_r;

  always_comb begin
    sel_short = (mod_side.func == FN_DECAY_S)  || (mod_side.func == FN_DECAY4_S) ||
                (mod_side.func == FN_SQ2_S)    || (mod_side.func == FN_SQ1_S);
    per = sel_short ? short_period_r : full_period_r;

    p1_nxt.func    = mod_side.func;
    p1_nxt.neg     = mod_side.neg;
    p1_nxt.lt_per  = !mod_side.neg && (CMP_W'(mod_side.mag) < CMP_W'(per));
    p1_nxt.lt_ramp = !mod_side.neg && (CMP_W'(mod_side.mag) < CMP_W'(ramp_length_r));
    p1_nxt.pv      = PERIOD_W'(mod_side.mag);
    p1_nxt.per     = per;
    p1_nxt.len     = ramp_length_r;
    p1_nxt.phase   = mod_side.phase;

    // reps * p, then reduce by up to three periods (valid only when p < per)
    unique case (mod_side.func)
      FN_DECAY4_F, FN_DECAY4_S: t = {p1_nxt.pv, 2'b00};
      FN_SQ2_F, FN_SQ2_S:       t = {1'b0, p1_nxt.pv, 1'b0};
      default:                  t = {2'b00, p1_nxt.pv};
    endcase
    per1 = T_W'(per);
    per2 = per1 << 1;
    per3 = per1 + per2;
    priority if (t >= per3)      tq = t - per3;
    else if (t >= per2)          tq = t - per2;
    else if (t >= per1)          tq = t - per1;
    else                         tq = t;
    p1_nxt.q = PERIOD_W'(tq);

    // non-negative p mod full_period
    if (full_period_r == '0)                   p1_nxt.m = '0;
    else if (mod_side.neg && (mod_rem != '0))  p1_nxt.m = full_period_r - mod_rem;
    else                                       p1_nxt.m = mod_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= mod_valid;
      p1_r       <= p1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // divider operands: level = (x * 2^16 + d/2) / d, or a fixed level
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0]  div_x;
  logic [PERIOD_W-1:0]  div_d;
  logic [DIV_NUM_W-1:0] div_num;
  div_side_t            div_side_in;

  always_comb begin
    div_x                 = '0;
    div_d                 = PERIOD_W'(1);
    div_side_in.use_div   = 1'b0;
    div_side_in.is_sine   = 1'b0;
    div_side_in.fixed_lvl = '0;
    div_side_in.phase     = p1_r.phase;
    unique case (func_t'(p1_r.func))
      FN_FULL: div_side_in.fixed_lvl = FULL_LEVEL;
      FN_DECAY_F, FN_DECAY_S, FN_DECAY4_F, FN_DECAY4_S: begin
        if (p1_r.neg) begin
          div_side_in.fixed_lvl = FULL_LEVEL;
        end else if (p1_r.lt_per) begin
          div_side_in.use_div = 1'b1;
          div_x               = p1_r.per - p1_r.q;
          div_d               = p1_r.per;
        end
      end
      FN_SQ2_F, FN_SQ2_S, FN_SQ1_F, FN_SQ1_S: begin
        if (p1_r.neg) begin
          div_side_in.fixed_lvl = FULL_LEVEL;
        end else if (p1_r.lt_per && (p1_r.q < (p1_r.per >> 1))) begin
          div_side_in.fixed_lvl = FULL_LEVEL;
        end
      end
      FN_SINE: begin
        // zero period leaves the phase alone: divide 0 by 1
        div_side_in.use_div = 1'b1;
        div_side_in.is_sine = 1'b1;
        div_x               = p1_r.m;
        div_d               = (p1_r.per == '0) ? PERIOD_W'(1) : p1_r.per;
      end
      FN_RAMP_ON: begin
        if (!p1_r.neg && !p1_r.lt_ramp) begin
          div_side_in.fixed_lvl = FULL_LEVEL;
        end else if (p1_r.lt_ramp) begin
          div_side_in.use_div = 1'b1;
          div_x               = p1_r.pv;
          div_d               = p1_r.len;
        end
      end
      FN_RAMP_OFF: begin
        if (p1_r.neg) begin
          div_side_in.fixed_lvl = FULL_LEVEL;
        end else if (p1_r.lt_ramp) begin
          div_side_in.use_div = 1'b1;
          div_x               = p1_r.len - p1_r.pv;
          div_d               = p1_r.len;
        end
      end
      default: ;  // zero pattern and unused codes
    endcase
    div_num = {div_x, FRAC_W'(0)} + DIV_NUM_W'(div_d >> 1);
  end

  logic                 div_valid;
  logic [DIV_NUM_W-1:0] div_quo;
  div_side_t            div_side;

  lepg_udiv #(
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (PERIOD_W),
    .side_t (div_side_t)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_valid_r),
    .num       (div_num),
    .den       (div_d),
    .side_in   (div_side_in),
    .out_valid (div_valid),
    .quo       (div_quo),
    .rem       (),
    .side_out  (div_side)
  );

  // ---------------------------------------------------------------------------
  // sine stages, with the other levels delayed alongside
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0] angle;
  logic [LEVEL_W-1:0] other_lvl;
  logic [LEVEL_W-1:0] sine_lvl;

  assign angle     = div_quo[PHASE_W-1:0] + div_side.phase;
  assign other_lvl = div_side.use_div ? div_quo[LEVEL_W-1:0] : div_side.fixed_lvl;

  lepg_sine #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk   (clk),
    .en    (en),
    .angle (angle),
    .level (sine_lvl)
  );

  logic               s_valid_r [0:2];
  logic               s_sine_r  [0:2];
  logic [LEVEL_W-1:0] s_lvl_r   [0:2];
  logic [LEVEL_W-1:0] out_level_nxt;
  logic [LEVEL_W-1:0] out_level_r;

  assign out_level_nxt = s_sine_r[2] ? sine_lvl : s_lvl_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r[0] <= 1'b0;
      s_valid_r[1] <= 1'b0;
      s_valid_r[2] <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      s_valid_r[0] <= div_valid;
      s_valid_r[1] <= s_valid_r[0];
      s_valid_r[2] <= s_valid_r[1];
      s_sine_r[0]  <= div_side.is_sine;
      s_sine_r[1]  <= s_sine_r[0];
      s_sine_r[2]  <= s_sine_r[1];
      s_lvl_r[0]   <= other_lvl;
      s_lvl_r[1]   <= s_lvl_r[0];
      s_lvl_r[2]   <= s_lvl_r[1];
      out_valid_r  <= s_valid_r[2];
      out_level_r  <= out_level_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // repeated-pattern reduction lands inside the period
  a_prep_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r && p1_r.lt_per |-> p1_r.q < p1_r.per)
    else $error("prep: reduced position not below period");

  // a held output freezes the prep stage
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> p1_valid_r == $past(p1_valid_r))
    else $error("pipeline moved during a stall");

  // fixed levels are only zero or full
  a_fixed_level: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && !div_side.use_div |->
      (div_side.fixed_lvl == '0) || (div_side.fixed_lvl == FULL_LEVEL))
    else $error("fixed level neither zero nor full");

  // sine always goes through the divider
  a_sine_uses_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_valid && div_side.is_sine |-> div_side.use_div)
    else $error("sine item bypassed the divider");

endmodule

`default_nettype wire
